// ===== design/rlesd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlesd_pkg
// Shared types, field widths and codes of the run-length sprite decoder.
// ----------------------------------------------------------------------------
package rlesd_pkg;

    // Field widths of the ports
    localparam int OPC_W     = 2;
    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 20;
    localparam int PIX_W     = 8;
    localparam int BYTES_W   = 24;
    localparam int RUN_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DIM_W = 11;

    // Defaults of the top-level parameters
    localparam int MAX_DIM_DEF   = 1024;
    localparam int TILE_SIZE_DEF = 64;

    // Results per item and the counter that holds 0..BEATS_MAX
    localparam int BEATS_MAX = 4;
    localparam int CNT_W     = 3;
    localparam int BEAT_W    = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Source word decoding
    localparam logic [PIX_W-1:0]   RUN_TAG   = 8'hFF;
    localparam logic [BYTES_W-1:0] BYTES_MAX = 24'hFFFFFF;
    localparam logic [BYTES_W-1:0] BYTES_PER_WORD = 24'd4;

    // Opcodes of the input channel
    localparam logic [OPC_W-1:0] OP_WORD  = 2'd0;
    localparam logic [OPC_W-1:0] OP_PULL  = 2'd1;
    localparam logic [OPC_W-1:0] OP_START = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_MODE     = 2'd2;

    // Clamped configuration as seen by the address generator
    typedef struct packed {
        logic [CFG_DIM_W-1:0] width;
        logic [CFG_DIM_W-1:0] height;
        logic                 tile_mode;
    } cfg_t;

    // One classified item, queued for the back end
    typedef struct packed {
        logic                            clear;
        logic [CNT_W-1:0]                count;
        logic [BEATS_MAX-1:0][PIX_W-1:0] values;
        logic                            run_pending;
        logic                            sprite_done;
        logic [BYTES_W-1:0]              bytes;
        logic                            perr;
    } entry_t;

endpackage

// ===== design/rlesd_front.sv =====
// ----------------------------------------------------------------------------
// rlesd_front
// Accepts input items, decodes words and runs, keeps the pixel, run and
// byte counters, and queues one classified entry per item.
// ----------------------------------------------------------------------------
module rlesd_front #(
    parameter int TGT_W = 21
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rlesd_pkg::OPC_W-1:0]    s_opcode,
    input  logic [rlesd_pkg::WORD_W-1:0]   s_compressed_word,
    input  logic                           s_end_of_stream,
    input  logic                           hold,
    input  logic [TGT_W-1:0]               target,
    input  logic                           q_full,
    output logic                           push,
    output rlesd_pkg::entry_t              push_entry
);
    import rlesd_pkg::*;

    logic [TGT_W-1:0]   emitted_reg, emitted_next;
    logic [RUN_W-1:0]   run_left_reg, run_left_next;
    logic [PIX_W-1:0]   run_pixel_reg, run_pixel_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic               finished_reg, finished_next;

    logic [TGT_W-1:0]   remaining;
    logic [TGT_W-1:0]   emitted_base;
    logic [CNT_W-1:0]   room;
    logic [CNT_W-1:0]   cnt;
    logic [RUN_W-1:0]   word_run;
    logic               all_now;
    logic               all_after;
    logic               word_ok;

    function automatic logic [CNT_W-1:0] take_count(input logic [RUN_W-1:0] avail,
                                                    input logic [CNT_W-1:0] cap);
        return (avail >= RUN_W'(cap)) ? cap : avail[CNT_W-1:0];
    endfunction

    assign s_ready = !q_full && !hold;
    assign push    = s_valid && s_ready;
    assign word_run = s_compressed_word[RUN_W-1:0];

    always_comb begin
        all_now   = emitted_reg >= target;
        remaining = all_now ? '0 : target - emitted_reg;
        room      = (remaining >= TGT_W'(BEATS_MAX)) ? CNT_W'(BEATS_MAX)
                                                     : remaining[CNT_W-1:0];
        word_ok   = !(finished_reg || (run_left_reg != '0) || all_now);

        emitted_base   = emitted_reg;
        run_left_next  = run_left_reg;
        run_pixel_next = run_pixel_reg;
        bytes_next     = bytes_reg;
        finished_next  = finished_reg;
        cnt            = '0;
        push_entry.values = {BEATS_MAX{run_pixel_reg}};
        push_entry.perr   = 1'b0;
        push_entry.clear  = 1'b0;

        unique case (s_opcode)
            OP_WORD: begin
                if (!word_ok) begin
                    push_entry.perr = 1'b1;
                end else begin
                    bytes_next = (bytes_reg > BYTES_MAX - BYTES_PER_WORD) ? BYTES_MAX
                                                                          : bytes_reg + BYTES_PER_WORD;
                    if (s_compressed_word[WORD_W-1 -: PIX_W] == RUN_TAG) begin
                        run_pixel_next    = s_compressed_word[RUN_W +: PIX_W];
                        cnt               = take_count(word_run, room);
                        run_left_next     = word_run - RUN_W'(cnt);
                        push_entry.values = {BEATS_MAX{s_compressed_word[RUN_W +: PIX_W]}};
                    end else begin
                        cnt               = room;
                        push_entry.values = s_compressed_word;
                    end
                    if (s_end_of_stream) begin
                        finished_next = 1'b1;
                    end
                end
            end
            OP_PULL: begin
                cnt           = take_count(run_left_reg, room);
                run_left_next = run_left_reg - RUN_W'(cnt);
            end
            OP_START: begin
                emitted_base     = '0;
                run_left_next    = '0;
                run_pixel_next   = '0;
                bytes_next       = '0;
                finished_next    = 1'b0;
                push_entry.clear = 1'b1;
            end
            default: begin
            end
        endcase

        emitted_next = emitted_base + TGT_W'(cnt);
        all_after    = emitted_next >= target;
        // a finished sprite drops whatever is left of the run
        if (all_after) begin
            run_left_next = '0;
        end

        push_entry.count       = cnt;
        push_entry.run_pending = run_left_next != '0;
        push_entry.sprite_done = finished_next || all_after;
        push_entry.bytes       = bytes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emitted_reg   <= '0;
            run_left_reg  <= '0;
            run_pixel_reg <= '0;
            bytes_reg     <= '0;
            finished_reg  <= 1'b0;
        end else if (push) begin
            emitted_reg   <= emitted_next;
            run_left_reg  <= run_left_next;
            run_pixel_reg <= run_pixel_next;
            bytes_reg     <= bytes_next;
            finished_reg  <= finished_next;
        end
    end

endmodule

// ===== design/rlesd_queue.sv =====
// ----------------------------------------------------------------------------
// rlesd_queue
// Short FIFO of classified entries between the front and the back end.
// ----------------------------------------------------------------------------
module rlesd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rlesd_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output rlesd_pkg::entry_t head
);
    import rlesd_pkg::*;

    entry_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg, fill_next;

    assign full       = fill_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head       = slots_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        priority if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== design/rlesd_back.sv =====
// ----------------------------------------------------------------------------
// rlesd_back
// Splits each queued entry into results, one a cycle unless stalled; walks
// the raster or tile scan to address pixels; holds results in an output stage.
// ----------------------------------------------------------------------------
module rlesd_back #(
    parameter int MAX_DIM   = rlesd_pkg::MAX_DIM_DEF,
    parameter int TILE_SIZE = rlesd_pkg::TILE_SIZE_DEF,
    parameter int TGT_W     = 21
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rlesd_pkg::cfg_t                cfg,
    input  logic                           head_valid,
    input  rlesd_pkg::entry_t              head,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rlesd_pkg::ADDR_W-1:0]   m_pixel_address,
    output logic [rlesd_pkg::PIX_W-1:0]    m_pixel_value,
    output logic                           m_write_enable,
    output logic                           m_item_last,
    output logic                           m_run_pending,
    output logic                           m_sprite_done,
    output logic [rlesd_pkg::BYTES_W-1:0]  m_bytes_consumed,
    output logic                           m_protocol_error
);
    import rlesd_pkg::*;

    localparam int DIM_CAP = (1 << CFG_DIM_W) - 1;
    localparam int DIM_EFF = (MAX_DIM > DIM_CAP) ? DIM_CAP : MAX_DIM;
    localparam int TIN_W   = $clog2(TILE_SIZE + 1);
    // After a geometry change, tile rows past the sprite edge can take as
    // little as one pixel each, so the row origin is bounded by the pixel
    // target times the tile size.
    localparam int BASE_W  = $clog2(DIM_EFF * DIM_EFF * TILE_SIZE + 1);
    localparam int CMP_W   = BASE_W + 1;
    localparam int PROD_W  = CMP_W + CFG_DIM_W;

    logic [BASE_W-1:0] row_tbase_reg, row_tbase_next;
    logic [BASE_W-1:0] col_tbase_reg, col_tbase_next;
    logic [TIN_W-1:0]  row_in_reg, row_in_next;
    logic [TIN_W-1:0]  col_in_reg, col_in_next;
    logic [TGT_W-1:0]  lin_reg, lin_next;
    logic [BEAT_W-1:0] beat_reg;

    logic               m_valid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PIX_W-1:0]   value_reg;
    logic               we_reg, last_reg, pend_reg, done_reg, perr_reg;
    logic [BYTES_W-1:0] bytes_reg;

    logic               fire;
    logic               we;
    logic               last;
    logic [CMP_W-1:0]   y;
    logic [CMP_W-1:0]   x;
    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  addr;
    logic [TIN_W-1:0]   col_step;
    logic [TIN_W-1:0]   row_step;
    logic               col_wrap;
    logic               row_wrap;
    logic               tcol_wrap;

    assign fire = head_valid && (!m_valid_reg || m_ready);
    assign we   = head.count != '0;
    assign last = (head.count <= CNT_W'(1)) ||
                  (beat_reg == BEAT_W'(head.count - CNT_W'(1)));
    assign pop  = fire && last;

    // destination address of the current pixel
    always_comb begin
        y    = CMP_W'(row_tbase_reg) + CMP_W'(row_in_reg);
        x    = CMP_W'(col_tbase_reg) + CMP_W'(col_in_reg);
        prod = PROD_W'(y) * PROD_W'(cfg.width);
        addr = cfg.tile_mode ? ADDR_W'(prod + PROD_W'(x)) : ADDR_W'(lin_reg);
    end

    // step the scan by one pixel; edge tiles are clipped to the sprite
    always_comb begin
        col_step  = col_in_reg + 1'b1;
        row_step  = row_in_reg + 1'b1;
        col_wrap  = (CMP_W'(col_tbase_reg) + CMP_W'(col_step) >= CMP_W'(cfg.width)) ||
                    (col_step >= TIN_W'(TILE_SIZE));
        row_wrap  = (CMP_W'(row_tbase_reg) + CMP_W'(row_step) >= CMP_W'(cfg.height)) ||
                    (row_step >= TIN_W'(TILE_SIZE));
        tcol_wrap = CMP_W'(col_tbase_reg) + CMP_W'(TILE_SIZE) >= CMP_W'(cfg.width);

        lin_next       = lin_reg + 1'b1;
        col_in_next    = col_step;
        row_in_next    = row_in_reg;
        col_tbase_next = col_tbase_reg;
        row_tbase_next = row_tbase_reg;
        if (col_wrap) begin
            col_in_next = '0;
            row_in_next = row_step;
            if (row_wrap) begin
                row_in_next = '0;
                if (tcol_wrap) begin
                    col_tbase_next = '0;
                    row_tbase_next = row_tbase_reg + BASE_W'(TILE_SIZE);
                end else begin
                    col_tbase_next = col_tbase_reg + BASE_W'(TILE_SIZE);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_tbase_reg <= '0;
            col_tbase_reg <= '0;
            row_in_reg    <= '0;
            col_in_reg    <= '0;
            lin_reg       <= '0;
            beat_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
                beat_reg    <= last ? '0 : beat_reg + 1'b1;
                priority if (head.clear) begin
                    row_tbase_reg <= '0;
                    col_tbase_reg <= '0;
                    row_in_reg    <= '0;
                    col_in_reg    <= '0;
                    lin_reg       <= '0;
                end else if (we) begin
                    row_tbase_reg <= row_tbase_next;
                    col_tbase_reg <= col_tbase_next;
                    row_in_reg    <= row_in_next;
                    col_in_reg    <= col_in_next;
                    lin_reg       <= lin_next;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            addr_reg  <= we ? addr : '0;
            value_reg <= we ? head.values[beat_reg] : '0;
            we_reg    <= we;
            last_reg  <= last;
            pend_reg  <= head.run_pending;
            done_reg  <= head.sprite_done;
            bytes_reg <= head.bytes;
            perr_reg  <= head.perr;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pixel_address  = addr_reg;
    assign m_pixel_value    = value_reg;
    assign m_write_enable   = we_reg;
    assign m_item_last      = last_reg;
    assign m_run_pending    = pend_reg;
    assign m_sprite_done    = done_reg;
    assign m_bytes_consumed = bytes_reg;
    assign m_protocol_error = perr_reg;

endmodule

// ===== design/rle_word_sprite_decoder_tiled.sv =====
// ----------------------------------------------------------------------------
// rle_word_sprite_decoder_tiled
// Run-length sprite decoder: 32-bit source words in, addressed pixel writes
// out, in raster or tiled order.
// ----------------------------------------------------------------------------
// Path: an item is queued, and its results are registered in an output stage.
// Throughput: one item per cycle while the queue is not full and the target
//   is not being recomputed; the back end emits one result per cycle unless
//   m_ready stalls it, so an item with n pixel writes (n from 1 to 4) gives n results.
// Reset: counters, queue and output stage clear; width and height reset to 1,
//   linear mode. The input stalls after reset and after each configuration
//   write while the pixel target is recomputed.
// ----------------------------------------------------------------------------
module rle_word_sprite_decoder_tiled #(
    parameter int MAX_DIM   = rlesd_pkg::MAX_DIM_DEF,
    parameter int TILE_SIZE = rlesd_pkg::TILE_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlesd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlesd_pkg::CFG_DIM_W-1:0]   cfg_data,
    // source items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rlesd_pkg::OPC_W-1:0]       s_opcode,
    input  logic [rlesd_pkg::WORD_W-1:0]      s_compressed_word,
    input  logic                              s_end_of_stream,
    // pixel results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rlesd_pkg::ADDR_W-1:0]      m_pixel_address,
    output logic [rlesd_pkg::PIX_W-1:0]       m_pixel_value,
    output logic                              m_write_enable,
    output logic                              m_item_last,
    output logic                              m_run_pending,
    output logic                              m_sprite_done,
    output logic [rlesd_pkg::BYTES_W-1:0]     m_bytes_consumed,
    output logic                              m_protocol_error
);
    import rlesd_pkg::*;

    // Dimensions clamp to MAX_DIM, and never above what the 11-bit fields hold.
    localparam int DIM_CAP = (1 << CFG_DIM_W) - 1;
    localparam int DIM_EFF = (MAX_DIM > DIM_CAP) ? DIM_CAP : MAX_DIM;
    localparam int TGT_W   = $clog2(DIM_EFF * DIM_EFF + 1);

    cfg_t               cfg_reg;
    logic               settle_reg;
    logic [TGT_W-1:0]   target_reg;
    logic [CFG_DIM_W-1:0] dim_clamped;
    logic               cfg_xfer;

    logic               push;
    entry_t             push_entry;
    logic               q_full;
    logic               pop;
    logic               head_valid;
    entry_t             head;

    // Configuration is always taken at once.
    assign cfg_ready   = 1'b1;
    assign cfg_xfer    = cfg_valid && cfg_ready;
    assign dim_clamped = (cfg_data > CFG_DIM_W'(DIM_EFF)) ? CFG_DIM_W'(DIM_EFF) : cfg_data;

    // Hold the clamped values; only the clamped values ever matter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width     <= CFG_DIM_W'(1);
            cfg_reg.height    <= CFG_DIM_W'(1);
            cfg_reg.tile_mode <= 1'b0;
            settle_reg        <= 1'b1;
        end else begin
            settle_reg <= cfg_xfer;
            if (cfg_xfer) begin
                unique case (cfg_index)
                    REG_SPRITE_WIDTH:  cfg_reg.width     <= dim_clamped;
                    REG_SPRITE_HEIGHT: cfg_reg.height    <= dim_clamped;
                    REG_TILE_MODE:     cfg_reg.tile_mode <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Pixel target width*height, registered off the compare path. The input
    // stalls while this register still lags the config.
    always_ff @(posedge aclk) begin
        target_reg <= TGT_W'(cfg_reg.width * cfg_reg.height);
    end

    // Front: accept, decode, count, queue.
    rlesd_front #(
        .TGT_W (TGT_W)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_compressed_word (s_compressed_word),
        .s_end_of_stream   (s_end_of_stream),
        .hold              (settle_reg),
        .target            (target_reg),
        .q_full            (q_full),
        .push              (push),
        .push_entry        (push_entry)
    );

    // Queue: lets the front keep taking items while the back drains bursts.
    rlesd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: one result per cycle unless m_ready stalls it, address walk, output stage.
    rlesd_back #(
        .MAX_DIM   (MAX_DIM),
        .TILE_SIZE (TILE_SIZE),
        .TGT_W     (TGT_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .head_valid       (head_valid),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_address  (m_pixel_address),
        .m_pixel_value    (m_pixel_value),
        .m_write_enable   (m_write_enable),
        .m_item_last      (m_item_last),
        .m_run_pending    (m_run_pending),
        .m_sprite_done    (m_sprite_done),
        .m_bytes_consumed (m_bytes_consumed),
        .m_protocol_error (m_protocol_error)
    );

    // A result without a write is always the only result of its item.
    a_nowrite_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_item_last)
        else $error("result without write is not the last of its item");

    // A result without a write carries a zero address and value.
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> (m_pixel_address == '0) && (m_pixel_value == '0))
        else $error("result without write carries nonzero payload");

    // After a transfer that is not the last of its item, the next result follows.
    a_burst_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item_last |=> m_valid)
        else $error("gap inside the results of one item");

    // A rejected word never writes a pixel.
    a_perr_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_protocol_error |-> !m_write_enable)
        else $error("rejected word produced a pixel write");

endmodule

// ===== tb/rle_word_sprite_decoder_tiled_test.sv =====
// ----------------------------------------------------------------------------
// rle_word_sprite_decoder_tiled_test
// Self-checking bench for the run-length sprite decoder. Source words, pulls
// and sprite starts go in through the valid/ready input port. A cycle-free
// decoder model in the bench predicts every pixel result, and each result
// transfer is checked in order against it. Directed corner cases come first,
// then randomized sprites under changing raster/tile configurations, with
// random stalls on both ports.
// ----------------------------------------------------------------------------
module rle_word_sprite_decoder_tiled_test;
    import rlesd_pkg::*;

    // Opcode 3 has no meaning in the decoder; it must give one result without a write.
    localparam logic [OPC_W-1:0]     OP_IGNORED = 2'd3;
    // Register index 3 is not mapped; writes to it must have no effect.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int unsigned TILE        = TILE_SIZE_DEF;
    localparam int unsigned DIM_LIMIT   = MAX_DIM_DEF;
    localparam int          QUIET_LIMIT = 1000;
    localparam int          SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [WORD_W-1:0] word;
        logic              eos;
    } src_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [PIX_W-1:0]   value;
        logic               wr_en;
        logic               last;
        logic               run_pend;
        logic               done;
        logic [BYTES_W-1:0] bytes;
        logic               perr;
    } px_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SPRITE_WIDTH;
    logic [CFG_DIM_W-1:0] cfg_data  = '0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OPC_W-1:0]     s_opcode = OP_WORD;
    logic [WORD_W-1:0]    s_compressed_word = '0;
    logic                 s_end_of_stream = 1'b0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ADDR_W-1:0]    m_pixel_address;
    logic [PIX_W-1:0]     m_pixel_value;
    logic                 m_write_enable;
    logic                 m_item_last;
    logic                 m_run_pending;
    logic                 m_sprite_done;
    logic [BYTES_W-1:0]   m_bytes_consumed;
    logic                 m_protocol_error;

    rle_word_sprite_decoder_tiled DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_compressed_word(s_compressed_word),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_address  (m_pixel_address),
        .m_pixel_value    (m_pixel_value),
        .m_write_enable   (m_write_enable),
        .m_item_last      (m_item_last),
        .m_run_pending    (m_run_pending),
        .m_sprite_done    (m_sprite_done),
        .m_bytes_consumed (m_bytes_consumed),
        .m_protocol_error (m_protocol_error)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    src_item_t  src_words[$];   // items waiting to be presented on the input
    px_result_t decoded_px[$];  // predicted pixel results, oldest first
    int         words_queued = 0;
    int         words_taken  = 0;
    int         failures     = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;
    logic       src_taken    = 1'b0;
    bit         calm_tail    = 1'b0;  // no stalls on either port once set
    int         src_gap      = 0;
    int         sink_gap     = 0;

    // ------------------------------------------------------------------------
    // Decoder model: configuration, sprite state and the per-item decode
    // ------------------------------------------------------------------------
    logic [CFG_DIM_W-1:0] cfg_width  = 11'd1;
    logic [CFG_DIM_W-1:0] cfg_height = 11'd1;
    logic                 cfg_tiled  = 1'b0;

    logic [20:0]          px_count   = '0;  // raw pixel index of the next write
    logic [RUN_W-1:0]     run_remaining = '0;
    logic [PIX_W-1:0]     run_value  = '0;
    logic [20:0]          tile_row   = '0;  // grows past the sprite after resizes
    logic [4:0]           tile_col   = '0;
    logic [5:0]           tile_y     = '0;
    logic [9:0]           tile_x     = '0;
    logic [BYTES_W-1:0]   byte_total = '0;
    logic                 stream_ended = 1'b0;

    // Writes produced by the item being decoded
    logic [ADDR_W-1:0]    beat_addr [BEATS_MAX];
    logic [PIX_W-1:0]     beat_val  [BEATS_MAX];
    int                   beat_cnt;

    function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v);
        int unsigned d = v;
        return (d > DIM_LIMIT) ? DIM_LIMIT : d;
    endfunction

    function automatic bit sprite_full();
        int unsigned goal = clamp_dim(cfg_width) * clamp_dim(cfg_height);
        return px_count >= goal;
    endfunction

    // Extent of a tile along one axis; tiles past the sprite count as one.
    function automatic int unsigned tile_span(int unsigned idx, int unsigned dim);
        longint unsigned origin = longint'(idx) * TILE;
        if (origin >= dim)
            return 1;
        if (dim - origin < TILE)
            return 32'(dim - origin);
        return TILE;
    endfunction

    // Return the destination of the next raw pixel, then step the raw index
    // and the tile walk: across a tile row, down the tile, then the next tile.
    function automatic logic [ADDR_W-1:0] advance_raster();
        int unsigned       w;
        int unsigned       h;
        int unsigned       tiles_across;
        int unsigned       step;
        longint unsigned   y;
        longint unsigned   x;
        logic [ADDR_W-1:0] line_base;
        logic [ADDR_W-1:0] addr;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        tiles_across = (w + TILE - 1) / TILE;
        y = longint'(tile_row) * TILE + tile_y;
        x = longint'(tile_col) * TILE + tile_x;
        line_base = 20'(y * w);
        addr = cfg_tiled ? line_base + 20'(x) : px_count[ADDR_W-1:0];

        px_count = px_count + 21'd1;
        step = tile_x + 1;
        if (step >= tile_span(tile_col, w)) begin
            tile_x = '0;
            step = tile_y + 1;
            if (step >= tile_span(tile_row, h)) begin
                tile_y = '0;
                step = tile_col + 1;
                if (step >= tiles_across) begin
                    tile_col = '0;
                    tile_row = tile_row + 21'd1;
                end else begin
                    tile_col = 5'(step);
                end
            end else begin
                tile_y = 6'(step);
            end
        end else begin
            tile_x = 10'(step);
        end
        return addr;
    endfunction

    function automatic void emit_px(logic [PIX_W-1:0] value);
        beat_addr[beat_cnt] = advance_raster();
        beat_val[beat_cnt]  = value;
        beat_cnt++;
    endfunction

    function automatic void drain_run();
        while (beat_cnt < BEATS_MAX && run_remaining != 0 && !sprite_full()) begin
            emit_px(run_value);
            run_remaining = run_remaining - 16'd1;
        end
    endfunction

    // Decode one accepted item and append its pixel results.
    function automatic void decode_item(src_item_t it);
        bit         rejected;
        int         n;
        int         k;
        px_result_t r;
        rejected = 1'b0;
        beat_cnt = 0;
        case (it.opcode)
            OP_WORD: begin
                if (stream_ended || run_remaining != 0 || sprite_full()) begin
                    rejected = 1'b1;
                end else begin
                    byte_total = (byte_total > BYTES_MAX - BYTES_PER_WORD) ?
                                 BYTES_MAX : byte_total + BYTES_PER_WORD;
                    if (it.word[31:24] == RUN_TAG) begin
                        run_remaining = it.word[RUN_W-1:0];
                        run_value     = it.word[23:16];
                        drain_run();
                    end else begin
                        for (k = 0; k < BEATS_MAX && !sprite_full(); k++)
                            emit_px(it.word[8*k +: 8]);
                    end
                    if (it.eos)
                        stream_ended = 1'b1;
                end
            end
            OP_PULL: drain_run();
            OP_START: begin
                px_count      = '0;
                run_remaining = '0;
                run_value     = '0;
                tile_row      = '0;
                tile_col      = '0;
                tile_y        = '0;
                tile_x        = '0;
                byte_total    = '0;
                stream_ended  = 1'b0;
            end
            default: ;
        endcase

        if (sprite_full())
            run_remaining = '0;
        n = (beat_cnt == 0) ? 1 : beat_cnt;
        for (k = 0; k < n; k++) begin
            r.addr     = (beat_cnt == 0) ? '0 : beat_addr[k];
            r.value    = (beat_cnt == 0) ? '0 : beat_val[k];
            r.wr_en    = (beat_cnt != 0);
            r.last     = (k == n - 1);
            r.run_pend = (run_remaining != 0);
            r.done     = stream_ended || sprite_full();
            r.bytes    = byte_total;
            r.perr     = rejected;
            decoded_px.insert(decoded_px.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Source driver: present queued items at the falling edge. Hold valid and
    // payload until the transfer; insert random idle bursts between items.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : source_drive
        src_item_t next_in;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || src_taken) begin
            if (src_gap != 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (src_words.size() != 0 && !calm_tail &&
                         $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 14);
                s_valid <= 1'b0;
            end else if (src_words.size() != 0) begin
                next_in = src_words.pop_front();
                s_valid           <= 1'b1;
                s_opcode          <= next_in.opcode;
                s_compressed_word <= next_in.word;
                s_end_of_stream   <= next_in.eos;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result sink: drop ready for random bursts.
    always @(negedge aclk) begin : sink_drive
        if (sink_gap != 0)
            sink_gap--;
        else if (!calm_tail && $urandom_range(0, 7) == 0)
            sink_gap = $urandom_range(1, 15);
        m_ready <= (sink_gap == 0);
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest prediction, then
    // decode any input transfer of the same edge. A result can never stem from
    // an item accepted at the same edge, so this order is safe.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        px_result_t seen;
        px_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_pixel_address, m_pixel_value, m_write_enable, m_item_last,
                     m_run_pending, m_sprite_done, m_bytes_consumed,
                     m_protocol_error};
            results_seen++;
            if (decoded_px.size() == 0) begin
                failures++;
                if (failures <= SHOW_LIMIT)
                    $display("result %0d: no result expected, got addr %h value %h",
                             results_seen, seen.addr, seen.value);
            end else begin
                want = decoded_px.pop_front();
                if (seen !== want) begin
                    failures++;
                    if (failures <= SHOW_LIMIT)
                        $display({"result %0d (expected/actual): addr %h/%h val %h/%h ",
                                  "we %b/%b last %b/%b pend %b/%b done %b/%b ",
                                  "bytes %h/%h perr %b/%b"},
                                 results_seen, want.addr, seen.addr,
                                 want.value, seen.value, want.wr_en, seen.wr_en,
                                 want.last, seen.last, want.run_pend, seen.run_pend,
                                 want.done, seen.done, want.bytes, seen.bytes,
                                 want.perr, seen.perr);
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            decode_item('{s_opcode, s_compressed_word, s_end_of_stream});
            words_taken <= words_taken + 1;
        end
        src_taken <= aresetn && s_valid && s_ready;
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rle_word_sprite_decoder_tiled regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(logic [OPC_W-1:0] op, logic [WORD_W-1:0] word, logic eos);
        src_item_t item;
        item = '{op, word, eos};
        src_words.insert(src_words.size(), item);
        words_queued++;
    endtask

    // Wait until every item is in and every result is out, then let the
    // pipeline go quiet before touching the registers.
    task automatic settle();
        while (words_taken != words_queued || decoded_px.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DIM_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            REG_SPRITE_WIDTH:  cfg_width  = data;
            REG_SPRITE_HEIGHT: cfg_height = data;
            REG_TILE_MODE:     cfg_tiled  = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(logic [CFG_DIM_W-1:0] w, logic [CFG_DIM_W-1:0] h, logic tiled);
        write_reg(REG_SPRITE_WIDTH, w);
        write_reg(REG_SPRITE_HEIGHT, h);
        write_reg(REG_TILE_MODE, {10'd0, tiled});
    endtask

    // Mostly well-formed sprites: literal words and runs followed by pulls that
    // drain short runs, at most eight, with occasional short drains, restarts and noise.
    task automatic queue_random_sprite(int count, bit fresh);
        int               pushed;
        int               roll;
        int               pulls;
        logic [WORD_W-1:0] w;
        logic [RUN_W-1:0]  len;
        pushed = 0;
        if (fresh) begin
            queue_word(OP_START, $urandom, 1'b0);
            pushed++;
        end
        while (pushed < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                queue_word(OP_START, $urandom, 1'($urandom_range(0, 1)));
                pushed++;
            end else if (roll < 15) begin
                queue_word(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
                pushed++;
            end else if (roll < 55) begin
                w = $urandom;
                if (w[31:24] == RUN_TAG)
                    w[31:24] = 8'($urandom_range(0, 254));
                queue_word(OP_WORD, w, $urandom_range(0, 24) == 0);
                pushed++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
                queue_word(OP_WORD, {RUN_TAG, 8'($urandom), len}, $urandom_range(0, 24) == 0);
                pushed++;
                pulls = (len > 4) ? (int'(len) - 1) / 4 : 0;
                if (pulls > 8)
                    pulls = 8;
                if (pulls > 0 && $urandom_range(0, 7) == 0)
                    pulls--;
                repeat (pulls) begin
                    queue_word(OP_PULL, $urandom, 1'b0);
                    pushed++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : sequencer
        logic [CFG_DIM_W-1:0] phase_w [12] = '{5, 3, 70, 40, 1, 64, 130, 7, 9, 1024, 65, 2};
        logic [CFG_DIM_W-1:0] phase_h [12] = '{3, 67, 2, 4, 1, 1, 3, 9, 7, 1024, 65, 5};
        bit                   phase_t [12] = '{0, 1, 1, 1, 1, 0, 1, 1, 0, 0, 1, 0};
        bit                   phase_f [12] = '{1, 1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1};
        int                   p;

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry is a single pixel: one write completes it, the next
        // word is a protocol error.
        queue_word(OP_WORD, 32'h0000_0000, 1'b0);
        queue_word(OP_WORD, 32'hFFFF_FFFF, 1'b0);
        settle();

        // 5x3 linear; also poke the unmapped register index
        set_geometry(11'd5, 11'd3, 1'b0);
        write_reg(REG_UNUSED, 11'h7FF);

        queue_word(OP_START,   32'h0000_0000, 1'b1);  // eos on a start is dropped
        queue_word(OP_WORD,    32'h0403_0201, 1'b0);  // four literals
        queue_word(OP_WORD,    32'hFEFF_FFFF, 1'b0);  // top byte not a run tag
        queue_word(OP_WORD,    32'hFFAB_0000, 1'b0);  // empty run
        queue_word(OP_WORD,    32'hFF5A_0006, 1'b0);  // run leaves two pending
        queue_word(OP_WORD,    32'h1234_5678, 1'b0);  // word during pending run
        queue_word(OP_PULL,    32'h0000_0000, 1'b1);  // drain, eos dropped
        queue_word(OP_PULL,    32'h0000_0000, 1'b0);  // nothing pending
        queue_word(OP_WORD,    32'hFF3C_0009, 1'b0);  // run hits the target
        queue_word(OP_PULL,    32'h0000_0000, 1'b0);
        queue_word(OP_WORD,    32'h1111_1111, 1'b0);  // word after done
        queue_word(OP_IGNORED, 32'hFFFF_FFFF, 1'b1);
        queue_word(OP_START,   32'h0000_0000, 1'b0);
        queue_word(OP_WORD,    32'hFF77_0008, 1'b1);  // end of stream on a run
        queue_word(OP_PULL,    32'h0000_0000, 1'b0);  // run still drains
        queue_word(OP_WORD,    32'h0000_0000, 1'b0);  // word after stream end
        queue_word(OP_START,   32'h0000_0000, 1'b0);
        queue_word(OP_WORD,    32'h8040_2010, 1'b1);  // end of stream on literals
        queue_word(OP_PULL,    32'h0000_0000, 1'b0);
        queue_word(OP_START,   32'h0000_0000, 1'b0);
        queue_word(OP_WORD,    32'hFF01_0020, 1'b0);  // long run left pending
        settle();

        // Shrink the target to what is already written mid-run: the sprite
        // is done and the pending run goes away.
        write_reg(REG_SPRITE_WIDTH, 11'd2);
        write_reg(REG_SPRITE_HEIGHT, 11'd2);
        queue_word(OP_PULL, 32'h0000_0000, 1'b0);
        settle();

        // Zero width: done straight after a start
        write_reg(REG_SPRITE_WIDTH, 11'd0);
        queue_word(OP_START, 32'h0000_0000, 1'b0);
        queue_word(OP_WORD,  32'h0102_0304, 1'b0);
        queue_word(OP_PULL,  32'h0000_0000, 1'b0);
        settle();

        // Oversized width clamps to the maximum; tiled, longest run
        set_geometry(11'h7FF, 11'd1024, 1'b1);
        queue_word(OP_START, 32'h0000_0000, 1'b0);
        queue_word(OP_WORD,  32'hFFC8_FFFF, 1'b0);
        queue_word(OP_PULL,  32'h0000_0000, 1'b0);
        queue_word(OP_PULL,  32'h0000_0000, 1'b0);
        queue_word(OP_WORD,  32'h5555_AAAA, 1'b0);
        settle();

        // Random sprites; phases without a start carry the counters over
        // into the new geometry. The last three phases run without stalls.
        for (p = 0; p < 12; p++) begin
            if (p == 9)
                calm_tail = 1'b1;
            set_geometry(phase_w[p], phase_h[p], phase_t[p]);
            queue_random_sprite(24, phase_f[p]);
            settle();
        end

        repeat (8) @(posedge aclk);
        if (failures == 0 && decoded_px.size() == 0)
            $display("rle_word_sprite_decoder_tiled regression: pass");
        else
            $display("rle_word_sprite_decoder_tiled regression: fail");
        $finish;
    end

endmodule
